// ----- hdl/rtpsrb_pkg.sv -----
// Package for the RTP sequence reorder buffer: payload structs, status codes,
// cell control struct and default sizes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rtpsrb_pkg;

    localparam int DEPTH_DEFAULT       = 64;
    localparam int SEQ_W               = 16;
    localparam int TAG_W               = 16;
    localparam int LEVEL_W             = 7;
    localparam int OCC_W               = 7;
    localparam logic [LEVEL_W-1:0] RELEASE_LEVEL_RESET = 7'd50;

    localparam logic ACT_PUT = 1'b0;
    localparam logic ACT_GET = 1'b1;

    localparam logic [1:0] ST_STORED   = 2'd0;
    localparam logic [1:0] ST_DUP      = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_GET      = 2'd3;

    typedef struct packed {
        logic             action;
        logic [SEQ_W-1:0] seq_num;
        logic [TAG_W-1:0] payload_tag;
        logic             drain;
    } in_item_t;

    typedef struct packed {
        logic             out_valid;
        logic [SEQ_W-1:0] out_seq;
        logic [TAG_W-1:0] out_tag;
        logic [1:0]       status;
        logic [OCC_W-1:0] occupancy;
    } out_item_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT_OUT
    } cell_op_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic             cmp_en;
        cell_op_t         op;
        logic [SEQ_W-1:0] key_seq;
        logic [TAG_W-1:0] key_tag;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/rtpsrb_cell.sv -----
// One slot of the sorted chain: holds an entry, compares it with the broadcast
// key, and takes its left or right neighbor's entry on insert or release.
// Depends on rtpsrb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtpsrb_cell
    import rtpsrb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cell_ctrl_t       ctrl,
    input  wire logic             occ,
    input  wire logic [SEQ_W-1:0] left_seq,
    input  wire logic [TAG_W-1:0] left_tag,
    input  wire logic             left_lt,
    input  wire logic [SEQ_W-1:0] right_seq,
    input  wire logic [TAG_W-1:0] right_tag,
    output logic [SEQ_W-1:0]      seq,
    output logic [TAG_W-1:0]      tag,
    output logic                  lt,
    output logic                  eq
);

    logic [SEQ_W-1:0] seq_reg;
    logic [TAG_W-1:0] tag_reg;
    logic             lt_reg;
    logic             eq_reg;
    logic [SEQ_W-1:0] seq_next;
    logic [TAG_W-1:0] tag_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else if (ctrl.cmp_en)
        begin
            lt_reg <= occ && (seq_reg < ctrl.key_seq);
            eq_reg <= occ && (seq_reg == ctrl.key_seq);
        end
    end

    // Entry below the insert point stays; the insert point takes the key;
    // everything above moves up by one.
    always_comb
    begin
        seq_next = seq_reg;
        tag_next = tag_reg;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
                seq_next = seq_reg;
                tag_next = tag_reg;
            end
            CELL_INSERT:
            begin
                if (!lt_reg)
                begin
                    if (left_lt)
                    begin
                        seq_next = ctrl.key_seq;
                        tag_next = ctrl.key_tag;
                    end
                    else
                    begin
                        seq_next = left_seq;
                        tag_next = left_tag;
                    end
                end
            end
            CELL_SHIFT_OUT:
            begin
                seq_next = right_seq;
                tag_next = right_tag;
            end
            default:
            begin
                seq_next = seq_reg;
                tag_next = tag_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        seq_reg <= seq_next;
        tag_reg <= tag_next;
    end

    assign seq = seq_reg;
    assign tag = tag_reg;
    assign lt  = lt_reg;
    assign eq  = eq_reg;

endmodule

`default_nettype wire

// ----- hdl/rtp_sequence_reorder_buffer.sv -----
// A result is registered in S_APPLY from the request held in req_reg.
// A new request is taken only in S_IDLE; the cells compare as it is accepted
// and shift in S_APPLY, and the next request waits for that shift.
// A result held by res_stall delays the shift, and with it the next request.
// Reset (rst_n, async): store empty, nothing released, release level 50.
// Entry data in the cells is not cleared; the fill count marks what is held.
`timescale 1ns / 1ps
`default_nettype none

module rtp_sequence_reorder_buffer
    import rtpsrb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire in_item_t           in_data,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output out_item_t               res_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [LEVEL_W-1:0] cfg_data
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > LEVEL_W) ? CW : LEVEL_W;

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } state_t;

    state_t             state_reg;
    in_item_t           req_reg;
    logic [CW-1:0]      count_reg;
    logic [SEQ_W-1:0]   last_rel_reg;
    logic               have_rel_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic               res_valid_reg;
    out_item_t          res_data_reg;

    cell_ctrl_t         ctrl;
    logic [SEQ_W-1:0]   seq_vec [DEPTH];
    logic [TAG_W-1:0]   tag_vec [DEPTH];
    logic [DEPTH-1:0]   lt_vec;
    logic [DEPTH-1:0]   eq_vec;
    logic [DEPTH-1:0]   occ_vec;

    logic               accept;
    logic               out_free;
    logic               apply;
    logic               is_dup;
    logic               is_full;
    logic               put_store;
    logic               consec;
    logic               release_ok;
    logic [CW-1:0]      count_next;
    logic [1:0]         status_now;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg == S_APPLY);
    assign out_free = !res_valid_reg || !res_stall;
    assign apply    = (state_reg == S_APPLY) && out_free;
    assign cfg_ready = 1'b1;

    assign is_dup    = |eq_vec;
    assign is_full   = (count_reg == CW'(DEPTH));
    assign put_store = (req_reg.action == ACT_PUT) && !is_dup && !is_full;
    assign consec    = ({1'b0, last_rel_reg} + 17'd1) == {1'b0, seq_vec[0]};
    assign release_ok = (req_reg.action == ACT_GET) && (count_reg != '0)
                        && (req_reg.drain || !have_rel_reg
                            || (CMPW'(count_reg) >= CMPW'(level_reg)) || consec);

    always_comb
    begin
        count_next = count_reg;
        status_now = ST_GET;
        if (req_reg.action == ACT_PUT)
        begin
            priority if (is_dup)
                status_now = ST_DUP;
            else if (is_full)
                status_now = ST_OVERFLOW;
            else
            begin
                status_now = ST_STORED;
                count_next = count_reg + 1'b1;
            end
        end
        else if (release_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        ctrl.cmp_en  = accept;
        ctrl.key_seq = accept ? in_data.seq_num : req_reg.seq_num;
        ctrl.key_tag = req_reg.payload_tag;
        ctrl.op      = CELL_HOLD;
        if (apply && put_store)
            ctrl.op = CELL_INSERT;
        else if (apply && release_ok)
            ctrl.op = CELL_SHIFT_OUT;
    end

    for (genvar gi = 0; gi < DEPTH; gi++)
    begin : g_cell
        logic [SEQ_W-1:0] l_seq;
        logic [TAG_W-1:0] l_tag;
        logic             l_lt;
        logic [SEQ_W-1:0] r_seq;
        logic [TAG_W-1:0] r_tag;

        assign occ_vec[gi] = (count_reg > CW'(gi));

        // head cell sees everything to its left as smaller
        if (gi == 0)
        begin : g_first
            assign l_seq = '0;
            assign l_tag = '0;
            assign l_lt  = 1'b1;
        end
        else
        begin : g_mid
            assign l_seq = seq_vec[gi-1];
            assign l_tag = tag_vec[gi-1];
            assign l_lt  = lt_vec[gi-1];
        end

        if (gi == DEPTH - 1)
        begin : g_last
            assign r_seq = '0;
            assign r_tag = '0;
        end
        else
        begin : g_inner
            assign r_seq = seq_vec[gi+1];
            assign r_tag = tag_vec[gi+1];
        end

        rtpsrb_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .occ       (occ_vec[gi]),
            .left_seq  (l_seq),
            .left_tag  (l_tag),
            .left_lt   (l_lt),
            .right_seq (r_seq),
            .right_tag (r_tag),
            .seq       (seq_vec[gi]),
            .tag       (tag_vec[gi]),
            .lt        (lt_vec[gi]),
            .eq        (eq_vec[gi])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= '0;
            count_reg     <= '0;
            last_rel_reg  <= '0;
            have_rel_reg  <= 1'b0;
            level_reg     <= RELEASE_LEVEL_RESET;
            res_valid_reg <= 1'b0;
            res_data_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                level_reg <= cfg_data;

            if (res_valid_reg && !res_stall && !apply)
                res_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg   <= in_data;
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY:
                begin
                    if (out_free)
                    begin
                        count_reg              <= count_next;
                        res_valid_reg          <= 1'b1;
                        res_data_reg.out_valid <= release_ok;
                        res_data_reg.out_seq   <= release_ok ? seq_vec[0] : '0;
                        res_data_reg.out_tag   <= release_ok ? tag_vec[0] : '0;
                        res_data_reg.status    <= status_now;
                        res_data_reg.occupancy <= OCC_W'(count_next);
                        if (release_ok)
                        begin
                            last_rel_reg <= seq_vec[0];
                            have_rel_reg <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

`ifndef SYNTHESIS
    // Cells below the insert point form a contiguous run from the head.
    a_sorted_run: assert property (@(posedge clk) disable iff (!rst_n)
        (lt_vec & (lt_vec + 1'b1)) == '0)
        else $error("less-than flags not contiguous from head");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count beyond depth");

    a_store_grows: assert property (@(posedge clk) disable iff (!rst_n)
        apply && put_store |=> count_reg == CW'($past(count_reg) + 1'b1))
        else $error("stored put did not grow the fill count");

    a_release_head: assert property (@(posedge clk) disable iff (!rst_n)
        apply && release_ok |=> res_valid_reg && res_data_reg.out_valid
            && (res_data_reg.out_seq == $past(seq_vec[0]))
            && (last_rel_reg == $past(seq_vec[0])))
        else $error("release did not report the head entry");
`endif

endmodule

`default_nettype wire

// ----- bench/rtpsrb_checker.sv -----
// Checker for the RTP sequence reorder buffer: watches the request, result and
// level-write channels, predicts each result and compares it field by field.
// Depends on rtpsrb_pkg.
`timescale 1ns / 1ps

module rtpsrb_checker
    import rtpsrb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire in_item_t           in_data,
    input  wire logic               res_valid,
    input  wire logic               res_stall,
    input  wire out_item_t          res_data,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [LEVEL_W-1:0] cfg_data,
    output int                      pending,
    output int                      mismatches,
    output int                      n_results,
    output int                      n_releases,
    output int                      n_drops
);

    localparam int MAX_PRINTS = 30;

    logic [SEQ_W-1:0]   held_seq [DEPTH];
    logic [TAG_W-1:0]   held_tag [DEPTH];
    int                 fill;
    logic [SEQ_W-1:0]   last_out;
    logic               released_any;
    logic [LEVEL_W-1:0] level;
    out_item_t          expected_q [$];

    task automatic report(input string field, input logic [31:0] got,
                          input logic [31:0] want);
        if (mismatches < MAX_PRINTS)
            $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h",
                     $time, field, got, want);
        mismatches++;
    endtask

    // Sorted insert on put; head release on get when one of the four
    // release conditions holds.
    task automatic predict_packet(input in_item_t req, output out_item_t res);
        int pos;
        res = '0;
        if (req.action == ACT_PUT)
        begin
            pos = 0;
            while (pos < fill && held_seq[pos] < req.seq_num)
                pos++;
            if (pos < fill && held_seq[pos] == req.seq_num)
                res.status = ST_DUP;
            else if (fill >= DEPTH)
                res.status = ST_OVERFLOW;
            else
            begin
                for (int k = fill; k > pos; k--)
                begin
                    held_seq[k] = held_seq[k-1];
                    held_tag[k] = held_tag[k-1];
                end
                held_seq[pos] = req.seq_num;
                held_tag[pos] = req.payload_tag;
                fill++;
                res.status = ST_STORED;
            end
        end
        else
        begin
            res.status = ST_GET;
            // +1 formed in 17 bits: a last number of 0xFFFF never matches
            if (fill != 0 && (req.drain || !released_any || fill >= level ||
                ({1'b0, last_out} + 17'd1) == {1'b0, held_seq[0]}))
            begin
                res.out_valid = 1'b1;
                res.out_seq   = held_seq[0];
                res.out_tag   = held_tag[0];
                for (int k = 1; k < fill; k++)
                begin
                    held_seq[k-1] = held_seq[k];
                    held_tag[k-1] = held_tag[k];
                end
                fill--;
                last_out     = res.out_seq;
                released_any = 1'b1;
            end
        end
        res.occupancy = OCC_W'(fill);
    endtask

    always @(posedge clk)
    begin : watch
        out_item_t predicted;
        out_item_t want;
        if (!rst_n)
        begin
            fill         = 0;
            last_out     = '0;
            released_any = 1'b0;
            level        = RELEASE_LEVEL_RESET;
            mismatches   = 0;
            n_results    = 0;
            n_releases   = 0;
            n_drops      = 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                level = cfg_data;
            if (in_valid && !in_stall)
            begin
                predict_packet(in_data, predicted);
                expected_q.insert(expected_q.size(), predicted);
            end
            if (res_valid && !res_stall)
            begin
                n_results++;
                if (expected_q.size() == 0)
                    report("result with no request pending", 32'(res_data.out_seq), '0);
                else
                begin
                    want = expected_q[0];
                    expected_q.delete(0);
                    if (res_data.out_valid !== want.out_valid)
                        report("out_valid", 32'(res_data.out_valid), 32'(want.out_valid));
                    if (res_data.out_seq !== want.out_seq)
                        report("out_seq", 32'(res_data.out_seq), 32'(want.out_seq));
                    if (res_data.out_tag !== want.out_tag)
                        report("out_tag", 32'(res_data.out_tag), 32'(want.out_tag));
                    if (res_data.status !== want.status)
                        report("status", 32'(res_data.status), 32'(want.status));
                    if (res_data.occupancy !== want.occupancy)
                        report("occupancy", 32'(res_data.occupancy),
                               32'(want.occupancy));
                    if (want.out_valid)
                        n_releases++;
                    if (want.status == ST_DUP || want.status == ST_OVERFLOW)
                        n_drops++;
                end
            end
        end
        pending <= expected_q.size();
    end

endmodule

// ----- bench/tb.sv -----
// Testbench top for the RTP sequence reorder buffer: clock, reset, directed and
// random packet traffic, level writes and the verdict.
// Depends on rtpsrb_pkg, rtp_sequence_reorder_buffer and rtpsrb_checker.
`timescale 1ns / 1ps

module tb;
    import rtpsrb_pkg::*;

    localparam int DEPTH       = 64;
    localparam int CYCLE_LIMIT = 400000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    in_item_t           in_data;
    logic               res_valid;
    logic               res_stall = 1'b0;
    out_item_t          res_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [LEVEL_W-1:0] cfg_data;

    int pending;
    int mismatches;
    int n_results;
    int n_releases;
    int n_drops;

    int               cycles = 0;
    int               send_idle_pct;
    int               stall_pct;
    int               n_puts;
    int               n_gets;
    logic [SEQ_W-1:0] stream_base;
    logic [SEQ_W-1:0] recent_seqs [$];

    rtp_sequence_reorder_buffer #(.DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    rtpsrb_checker #(.DEPTH(DEPTH)) chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .mismatches (mismatches),
        .n_results  (n_results),
        .n_releases (n_releases),
        .n_drops    (n_drops)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge clk)
        res_stall <= ($urandom_range(0, 99) < stall_pct);

    // Mostly a jittered stream around stream_base, with repeats of recent
    // numbers for duplicates and some fully random numbers.
    function automatic in_item_t gen_packet(input int put_pct, input int drain_pct,
                                            input int win);
        in_item_t p;
        int       pick;
        p.payload_tag = TAG_W'($urandom);
        p.drain       = ($urandom_range(0, 99) < drain_pct);
        p.action      = ($urandom_range(0, 99) < put_pct) ? ACT_PUT : ACT_GET;
        pick          = $urandom_range(0, 99);
        if (pick < 8)
            p.seq_num = SEQ_W'($urandom);
        else if (pick < 18 && recent_seqs.size() != 0)
            p.seq_num = recent_seqs[$urandom_range(0, recent_seqs.size() - 1)];
        else
        begin
            p.seq_num = stream_base + SEQ_W'($urandom_range(0, win));
            if (p.action == ACT_PUT && $urandom_range(0, 99) < 60)
                stream_base = stream_base + 1'b1;
        end
        if (p.action == ACT_PUT)
        begin
            recent_seqs.insert(recent_seqs.size(), p.seq_num);
            if (recent_seqs.size() > 16)
                recent_seqs.delete(0);
        end
        return p;
    endfunction

    task automatic send_req(input in_item_t req);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (in_stall);
        if (req.action == ACT_PUT)
            n_puts++;
        else
            n_gets++;
    endtask

    task automatic send_fields(input logic act, input logic [SEQ_W-1:0] seq,
                               input logic [TAG_W-1:0] tag, input logic drn);
        in_item_t req;
        req.action      = act;
        req.seq_num     = seq;
        req.payload_tag = tag;
        req.drain       = drn;
        send_req(req);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_level(input logic [LEVEL_W-1:0] lvl);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= lvl;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [LEVEL_W-1:0] lvl, input int s_idle,
                             input int r_stall, input int count, input int put_pct,
                             input int drain_pct, input int win);
        wait_idle();
        write_level(lvl);
        send_idle_pct = s_idle;
        stall_pct     = r_stall;
        repeat (count)
            send_req(gen_packet(put_pct, drain_pct, win));
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        n_puts        = 0;
        n_gets        = 0;
        stream_base   = SEQ_W'($urandom_range(0, 60000));
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset release level
        send_fields(ACT_GET, 16'd0,     16'h0000, 1'b0); // get on empty store
        send_fields(ACT_GET, 16'd0,     16'h0000, 1'b1); // drain on empty store
        send_fields(ACT_PUT, 16'd5,     16'hFFFF, 1'b1); // drain ignored on put
        send_fields(ACT_PUT, 16'd5,     16'h0001, 1'b0); // duplicate
        send_fields(ACT_PUT, 16'd0,     16'h0000, 1'b0);
        send_fields(ACT_PUT, 16'hFFFF,  16'hA5A5, 1'b0);
        send_fields(ACT_PUT, 16'd3,     16'h5A5A, 1'b0);
        send_fields(ACT_GET, 16'hFFFF,  16'hFFFF, 1'b0); // first release
        send_fields(ACT_GET, 16'd0,     16'h0000, 1'b0); // gap, held
        send_fields(ACT_PUT, 16'd1,     16'h1234, 1'b0);
        send_fields(ACT_GET, 16'd0,     16'h0000, 1'b0); // consecutive
        send_fields(ACT_GET, 16'd0,     16'h0000, 1'b0); // gap, held
        send_fields(ACT_GET, 16'd0,     16'h0000, 1'b1); // drain past gap
        send_fields(ACT_GET, 16'd0,     16'h0000, 1'b0);
        send_fields(ACT_PUT, 16'd4,     16'h8001, 1'b0);
        send_fields(ACT_GET, 16'd0,     16'h0000, 1'b0);
        send_fields(ACT_GET, 16'd0,     16'h0000, 1'b0);
        send_fields(ACT_GET, 16'd0,     16'h0000, 1'b1); // releases 0xFFFF
        send_fields(ACT_PUT, 16'd0,     16'hFFFF, 1'b0);
        send_fields(ACT_GET, 16'd0,     16'h0000, 1'b0); // no wrap after 0xFFFF
        send_fields(ACT_GET, 16'd0,     16'h0000, 1'b1);
        send_fields(ACT_GET, 16'd0,     16'h0000, 1'b0);

        run_phase(7'd1,   0,  0,  60, 55, 10, 6);
        run_phase(7'd64,  70, 0,  80, 60, 15, 6);
        // level above depth, no drain: fills up and overflows
        run_phase(7'd127, 0,  70, 110, 95, 0, 200);
        run_phase(7'd0,   31, 31, 60, 25, 10, 6);
        stream_base = 16'd65500;
        run_phase(7'd8,   0,  0,  80, 55, 5,  4);
        run_phase(LEVEL_W'($urandom_range(2, 63)), 31, 31, 100, 50, 20, 8);

        wait_idle();
        repeat (8) @(posedge clk);

        $display("Run: %0d requests (%0d puts, %0d gets), release levels 50, 1, 64, 127, 0, 8",
                 n_puts + n_gets, n_puts, n_gets);
        $display("and one random level; results checked: %0d, releases: %0d, dropped: %0d",
                 n_results, n_releases, n_drops);
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/rtpsrb_pkg.sv
hdl/rtpsrb_cell.sv
hdl/rtp_sequence_reorder_buffer.sv
bench/rtpsrb_checker.sv
bench/tb.sv
